// ===== rtl/vcp_pkg.sv =====
`timescale 1ns / 1ps

package vcp_pkg;

  // Video RAM size and the width of the table base addresses on the result.
  localparam int VRAM_DEPTH_DEF = 16384;
  localparam int TBL_AW         = 14;

  // Bus operations
  typedef enum logic [2:0] {
    OP_DATA_RD   = 3'd0,
    OP_STATUS_RD = 3'd1,
    OP_DATA_WR   = 3'd2,
    OP_CTRL_WR   = 3'd3,
    OP_FRAME_END = 3'd4
  } opcode_t;

  // Action field (bits 7:6) of the second control byte
  localparam logic [1:0] CW_READ_ADDR  = 2'b00;
  localparam logic [1:0] CW_WRITE_ADDR = 2'b01;
  localparam logic [1:0] CW_REG_WRITE  = 2'b10;

  // Chip register indexes
  localparam logic [2:0] REG_MODE0   = 3'd0;
  localparam logic [2:0] REG_MODE1   = 3'd1;
  localparam logic [2:0] REG_NAME    = 3'd2;
  localparam logic [2:0] REG_COLOR   = 3'd3;
  localparam logic [2:0] REG_PATTERN = 3'd4;
  localparam logic [2:0] REG_SATTR   = 3'd5;
  localparam logic [2:0] REG_SPAT    = 3'd6;
  localparam logic [2:0] REG_COLORS  = 3'd7;

  // Screen modes
  localparam logic [1:0] MODE_TEXT40 = 2'd0;
  localparam logic [1:0] MODE_TEXT32 = 2'd1;
  localparam logic [1:0] MODE_BITMAP = 2'd2;
  localparam logic [1:0] MODE_MULTI  = 2'd3;

  // Mode keys: {reg1[4:3], reg0[3:1]}
  localparam logic [4:0] KEY_TEXT40 = 5'h10;
  localparam logic [4:0] KEY_TEXT32 = 5'h00;
  localparam logic [4:0] KEY_BITMAP = 5'h01;
  localparam logic [4:0] KEY_MULTI  = 5'h08;

  // Reset values and bit masks
  localparam logic [7:0] REG1_RESET      = 8'h10;
  localparam logic [7:0] STATUS_RESET    = 8'h9F;
  localparam logic [7:0] STATUS_RD_MASK  = 8'h5F;
  localparam logic [7:0] STATUS_FE_MASK  = 8'hDF;
  localparam logic [7:0] STATUS_VBLANK   = 8'h80;
  localparam logic [7:0] REG6_MASK       = 8'h3F;
  localparam logic [7:0] VRAM_FILL       = 8'hFF;
  localparam int         IRQ_ENABLE_BIT  = 5;

  typedef struct packed {
    logic [7:0] m2;
    logic [7:0] m3;
    logic [7:0] m4;
    logic [7:0] m5;
  } masks_t;

  // Memory request from the control logic
  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } mem_req_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]        read_data;
    logic              vblank_interrupt;
    logic [1:0]        mode_out;
    logic [TBL_AW-1:0] name_table_addr;
    logic [TBL_AW-1:0] color_table_addr;
    logic [TBL_AW-1:0] pattern_table_addr;
    logic [TBL_AW-1:0] sprite_attr_addr;
    logic [TBL_AW-1:0] sprite_pattern_addr;
    logic [3:0]        fore_color;
    logic [3:0]        back_color;
  } res_t;

  function automatic masks_t mode_masks(input logic [1:0] m);
    masks_t k;
    case (m)
      MODE_TEXT40: k = '{m2: 8'h7F, m3: 8'h00, m4: 8'h3F, m5: 8'h00};
      MODE_TEXT32: k = '{m2: 8'h7F, m3: 8'hFF, m4: 8'h3F, m5: 8'hFF};
      MODE_BITMAP: k = '{m2: 8'h7F, m3: 8'h80, m4: 8'h3C, m5: 8'hFF};
      default:     k = '{m2: 8'h7F, m3: 8'h00, m4: 8'h3F, m5: 8'hFF};
    endcase
    return k;
  endfunction

  // Table bases, already cut to the table address width
  function automatic logic [TBL_AW-1:0] name_base_f(input logic [7:0] v, input logic [7:0] m);
    return {v[3:0] & m[3:0], 10'b0};
  endfunction

  function automatic logic [TBL_AW-1:0] color_base_f(input logic [7:0] v, input logic [7:0] m);
    return {v & m, 6'b0};
  endfunction

  function automatic logic [TBL_AW-1:0] pattern_base_f(input logic [7:0] v,
                                                       input logic [7:0] m);
    return {v[2:0] & m[2:0], 11'b0};
  endfunction

  function automatic logic [TBL_AW-1:0] sattr_base_f(input logic [7:0] v, input logic [7:0] m);
    return {v[6:0] & m[6:0], 7'b0};
  endfunction

  function automatic logic [TBL_AW-1:0] spat_base_f(input logic [7:0] v);
    return {v[2:0], 11'b0};
  endfunction

endpackage

// ===== rtl/vcp_if.sv =====
`timescale 1ns / 1ps

// Command channel: one bus access or frame-end event per transaction
interface vcp_cmd_if;
  import vcp_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

// Result channel: one transaction per command
interface vcp_res_if;
  import vcp_pkg::*;

  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic              vblank_interrupt;
  logic [1:0]        mode_out;
  logic [TBL_AW-1:0] name_table_addr;
  logic [TBL_AW-1:0] color_table_addr;
  logic [TBL_AW-1:0] pattern_table_addr;
  logic [TBL_AW-1:0] sprite_attr_addr;
  logic [TBL_AW-1:0] sprite_pattern_addr;
  logic [3:0]        fore_color;
  logic [3:0]        back_color;

  modport source (output valid, output read_data, output vblank_interrupt, output mode_out,
                  output name_table_addr, output color_table_addr, output pattern_table_addr,
                  output sprite_attr_addr, output sprite_pattern_addr, output fore_color,
                  output back_color, input ready);
  modport sink   (input valid, input read_data, input vblank_interrupt, input mode_out,
                  input name_table_addr, input color_table_addr, input pattern_table_addr,
                  input sprite_attr_addr, input sprite_pattern_addr, input fore_color,
                  input back_color, output ready);
endinterface

// ===== rtl/vcp_vram.sv =====
`timescale 1ns / 1ps

module vcp_vram #(
  parameter int VRAM_DEPTH = vcp_pkg::VRAM_DEPTH_DEF,
  parameter int VAW        = $clog2(VRAM_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  vcp_pkg::mem_req_t  req,
  input  logic [VAW-1:0]     waddr,
  input  logic [VAW-1:0]     raddr,
  output logic [7:0]         rdata,
  output logic               clearing
);
  import vcp_pkg::*;

  localparam logic [VAW-1:0] LAST_ADDR = VAW'(VRAM_DEPTH - 1);

  logic [7:0]     mem [VRAM_DEPTH];
  logic [VAW-1:0] clr_addr;

  // Fill sweep after reset, one byte per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= VRAM_FILL;
    end else if (req.we) begin
      mem[waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vcp_ctrl.sv =====
`timescale 1ns / 1ps

module vcp_ctrl #(
  parameter int VRAM_DEPTH = vcp_pkg::VRAM_DEPTH_DEF,
  parameter int VAW        = $clog2(VRAM_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [2:0]         opcode,
  input  logic [7:0]         data_in,
  output vcp_pkg::mem_req_t  mem_req,
  output logic [VAW-1:0]     mem_waddr,
  output logic [VAW-1:0]     mem_raddr,
  output logic               vram_rd,
  output vcp_pkg::res_t      step_res
);
  import vcp_pkg::*;

  // Architectural state
  logic [VAW-1:0]    write_addr, write_addr_next;
  logic [VAW-1:0]    read_addr, read_addr_next;
  logic              latch_armed, latch_armed_next;
  logic [7:0]        latch_byte, latch_byte_next;
  logic [7:0]        vdp_regs [8];
  logic [7:0]        vdp_regs_next [8];
  logic [7:0]        status_reg, status_reg_next;
  logic [1:0]        screen_mode, screen_mode_next;
  logic [TBL_AW-1:0] name_base, name_base_next;
  logic [TBL_AW-1:0] color_base, color_base_next;
  logic [TBL_AW-1:0] pattern_base, pattern_base_next;
  logic [TBL_AW-1:0] sattr_base, sattr_base_next;

  logic [7:0] status_rd;
  logic       irq;

  // Next-state logic for one transaction
  always_comb begin
    masks_t      cur_k;
    masks_t      new_k;
    logic [2:0]  r;
    logic [7:0]  v;
    logic [7:0]  r0;
    logic [7:0]  r1;
    logic [4:0]  key;
    logic [1:0]  m_sel;
    logic [15:0] addr_word;

    write_addr_next   = write_addr;
    read_addr_next    = read_addr;
    latch_armed_next  = latch_armed;
    latch_byte_next   = latch_byte;
    vdp_regs_next     = vdp_regs;
    status_reg_next   = status_reg;
    screen_mode_next  = screen_mode;
    name_base_next    = name_base;
    color_base_next   = color_base;
    pattern_base_next = pattern_base;
    sattr_base_next   = sattr_base;
    mem_req           = '{we: 1'b0, re: 1'b0, wdata: data_in};
    vram_rd           = 1'b0;
    status_rd         = 8'h00;
    irq               = 1'b0;

    cur_k     = mode_masks(screen_mode);
    r         = data_in[2:0];
    v         = latch_byte;
    r0        = (r == REG_MODE0) ? v : vdp_regs[0];
    r1        = (r == REG_MODE1) ? v : vdp_regs[1];
    key       = {r1[4:3], r0[3:1]};
    addr_word = 16'h0000;

    unique case (key)
      KEY_TEXT40: m_sel = MODE_TEXT40;
      KEY_TEXT32: m_sel = MODE_TEXT32;
      KEY_BITMAP: m_sel = MODE_BITMAP;
      KEY_MULTI:  m_sel = MODE_MULTI;
      default:    m_sel = screen_mode;
    endcase
    new_k = mode_masks(m_sel);

    if (take) begin
      unique case (opcode)
        OP_DATA_RD: begin
          mem_req.re     = 1'b1;
          vram_rd        = 1'b1;
          read_addr_next = read_addr + 1'b1;
        end
        OP_STATUS_RD: begin
          status_rd        = status_reg;
          status_reg_next  = status_reg & STATUS_RD_MASK;
          latch_armed_next = 1'b1;
        end
        OP_DATA_WR: begin
          if (latch_armed) begin
            mem_req.we      = 1'b1;
            write_addr_next = write_addr + 1'b1;
          end
        end
        OP_CTRL_WR: begin
          if (latch_armed) begin
            latch_byte_next  = data_in;
            latch_armed_next = 1'b0;
          end else begin
            latch_armed_next = 1'b1;
            unique case (data_in[7:6])
              CW_REG_WRITE: begin
                // Register write: latched byte goes to register data_in[2:0]
                unique case (r) inside
                  REG_MODE0, REG_MODE1: begin
                    if (m_sel != screen_mode) begin
                      screen_mode_next  = m_sel;
                      name_base_next    = name_base_f(vdp_regs[2], new_k.m2);
                      color_base_next   = color_base_f(vdp_regs[3], new_k.m3);
                      pattern_base_next = pattern_base_f(vdp_regs[4], new_k.m4);
                      sattr_base_next   = sattr_base_f(vdp_regs[5], new_k.m5);
                    end
                  end
                  REG_NAME:    name_base_next    = name_base_f(v, cur_k.m2);
                  REG_COLOR:   color_base_next   = color_base_f(v, cur_k.m3);
                  REG_PATTERN: pattern_base_next = pattern_base_f(v, cur_k.m4);
                  REG_SATTR:   sattr_base_next   = sattr_base_f(v, cur_k.m5);
                  default: ;
                endcase
                vdp_regs_next[r] = (r == REG_SPAT) ? (v & REG6_MASK) : v;
              end
              CW_WRITE_ADDR: begin
                addr_word       = {2'b00, data_in[5:0], latch_byte};
                write_addr_next = addr_word[VAW-1:0];
              end
              CW_READ_ADDR: begin
                addr_word      = {data_in, latch_byte};
                read_addr_next = addr_word[VAW-1:0];
              end
              default: ;
            endcase
          end
        end
        OP_FRAME_END: begin
          status_reg_next = (status_reg & STATUS_FE_MASK) | STATUS_VBLANK;
          irq             = latch_armed & vdp_regs[1][IRQ_ENABLE_BIT];
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_addr   <= '0;
      read_addr    <= '0;
      latch_armed  <= 1'b1;
      latch_byte   <= 8'h00;
      for (int i = 0; i < 8; i++) begin
        vdp_regs[i] <= (i == int'(REG_MODE1)) ? REG1_RESET : 8'h00;
      end
      status_reg   <= STATUS_RESET;
      screen_mode  <= MODE_TEXT40;
      name_base    <= '0;
      color_base   <= '0;
      pattern_base <= '0;
      sattr_base   <= '0;
    end else begin
      write_addr   <= write_addr_next;
      read_addr    <= read_addr_next;
      latch_armed  <= latch_armed_next;
      latch_byte   <= latch_byte_next;
      vdp_regs     <= vdp_regs_next;
      status_reg   <= status_reg_next;
      screen_mode  <= screen_mode_next;
      name_base    <= name_base_next;
      color_base   <= color_base_next;
      pattern_base <= pattern_base_next;
      sattr_base   <= sattr_base_next;
    end
  end

  assign mem_waddr = write_addr;
  assign mem_raddr = read_addr;

  // Result fields show the state after the transaction
  always_comb begin
    step_res.read_data           = status_rd;
    step_res.vblank_interrupt    = irq;
    step_res.mode_out            = screen_mode_next;
    step_res.name_table_addr     = name_base_next;
    step_res.color_table_addr    = color_base_next;
    step_res.pattern_table_addr  = pattern_base_next;
    step_res.sprite_attr_addr    = sattr_base_next;
    step_res.sprite_pattern_addr = spat_base_f(vdp_regs_next[REG_SPAT]);
    step_res.fore_color          = vdp_regs_next[REG_COLORS][7:4];
    step_res.back_color          = vdp_regs_next[REG_COLORS][3:0];
  end

endmodule

// ===== rtl/video_chip_cpu_port_core.sv =====
`timescale 1ns / 1ps
// CPU port of a video display chip with 16K of video RAM.
// cmd: one transaction per bus access or frame-end event (opcode, data_in).
// res: exactly one transaction per command, in order: read_data for reads,
//   the vblank interrupt flag, and the screen mode, table bases and colors
//   as they stand after the command.
// A taken command passes the middle stage, which waits for the registered
//   video RAM read, and then the output register. Throughput: one command per
//   cycle while neither a result stall nor the reset fill holds cmd.ready low.
// Reset (rst, synchronous): clears the control state and the pipeline valid flags
//   to their power-up values, then fills the video RAM with 0xFF, one byte per
//   cycle. cmd.ready stays low for the whole fill.
// Stall: when res.ready is low the result stays in the output register;
//   one more command is taken into the middle stage, after which cmd.ready
//   drops until the receiver takes the result.
module video_chip_cpu_port_core #(
  parameter int VRAM_DEPTH = vcp_pkg::VRAM_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  vcp_cmd_if.sink   cmd,
  vcp_res_if.source res
);
  import vcp_pkg::*;

  localparam int VAW = $clog2(VRAM_DEPTH);

  mem_req_t       mem_req;
  logic [VAW-1:0] mem_waddr;
  logic [VAW-1:0] mem_raddr;
  logic [7:0]     mem_rdata;
  logic           clearing;
  logic           take;
  logic           vram_rd;
  res_t           step_res;

  // Middle stage: waits for the video RAM read data
  logic b_valid;
  logic b_vram_rd;
  res_t b_res;
  res_t b_out;
  // Output register
  logic c_valid;
  res_t c_res;
  logic c_load;

  assign c_load    = b_valid & (~c_valid | res.ready);
  assign cmd.ready = ~clearing & (~b_valid | c_load);
  assign take      = cmd.valid & cmd.ready;

  vcp_ctrl #(
    .VRAM_DEPTH (VRAM_DEPTH),
    .VAW        (VAW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .opcode    (cmd.opcode),
    .data_in   (cmd.data_in),
    .mem_req   (mem_req),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .vram_rd   (vram_rd),
    .step_res  (step_res)
  );

  vcp_vram #(
    .VRAM_DEPTH (VRAM_DEPTH),
    .VAW        (VAW)
  ) u_vram (
    .clk      (clk),
    .rst      (rst),
    .req      (mem_req),
    .waddr    (mem_waddr),
    .raddr    (mem_raddr),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (take) begin
        b_valid <= 1'b1;
      end else if (c_load) begin
        b_valid <= 1'b0;
      end
      if (c_load) begin
        c_valid <= 1'b1;
      end else if (res.ready) begin
        c_valid <= 1'b0;
      end
    end
  end

  // Middle stage result with the video RAM byte merged in for data reads
  always_comb begin
    b_out = b_res;
    if (b_vram_rd) begin
      b_out.read_data = mem_rdata;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (take) begin
      b_res     <= step_res;
      b_vram_rd <= vram_rd;
    end
    if (c_load) begin
      c_res <= b_out;
    end
  end

  assign res.valid               = c_valid;
  assign res.read_data           = c_res.read_data;
  assign res.vblank_interrupt    = c_res.vblank_interrupt;
  assign res.mode_out            = c_res.mode_out;
  assign res.name_table_addr     = c_res.name_table_addr;
  assign res.color_table_addr    = c_res.color_table_addr;
  assign res.pattern_table_addr  = c_res.pattern_table_addr;
  assign res.sprite_attr_addr    = c_res.sprite_attr_addr;
  assign res.sprite_pattern_addr = c_res.sprite_pattern_addr;
  assign res.fore_color          = c_res.fore_color;
  assign res.back_color          = c_res.back_color;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vcp_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 8;

  // One pending bus transaction; drain makes the driver wait for all results first
  typedef struct {
    logic [2:0] op;
    logic [7:0] data;
    bit         drain;
  } bus_access_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vcp_cmd_if cmd_ch();
  vcp_res_if res_ch();

  video_chip_cpu_port_core DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bus_access_t bus_ops[$];
  res_t        predicted[$];
  int          total_ops     = 0;
  int          cmds_taken    = 0;
  int          results_seen  = 0;
  int          errors        = 0;
  int          cycle_count   = 0;
  int          hold_left     = 0;
  int          holds_started = 0;

  // Shadow copy of the chip state
  logic [7:0]  vram_img [VRAM_DEPTH_DEF];
  logic [13:0] wr_ptr, rd_ptr;
  logic        latch_armed;
  logic [7:0]  latch_lo;
  logic [7:0]  chip_regs [8];
  logic [7:0]  status_byte;
  logic [1:0]  cur_mode;
  logic [13:0] name_base, color_base, pattern_base, sattr_base, spat_base;
  logic [3:0]  fg_nib, bg_nib;

  function automatic masks_t table_masks(logic [1:0] m);
    masks_t k;
    case (m)
      MODE_TEXT40: k = '{m2: 8'h7F, m3: 8'h00, m4: 8'h3F, m5: 8'h00};
      MODE_TEXT32: k = '{m2: 8'h7F, m3: 8'hFF, m4: 8'h3F, m5: 8'hFF};
      MODE_BITMAP: k = '{m2: 8'h7F, m3: 8'h80, m4: 8'h3C, m5: 8'hFF};
      default:     k = '{m2: 8'h7F, m3: 8'h00, m4: 8'h3F, m5: 8'hFF};
    endcase
    return k;
  endfunction

  // Byte placed at a bit offset, cut to the table address width
  function automatic logic [13:0] at_bits(logic [7:0] v, int unsigned sh);
    return 14'(v) << sh;
  endfunction

  function automatic void rebase_tables(logic [1:0] m);
    masks_t k;
    k = table_masks(m);
    name_base    = at_bits(chip_regs[REG_NAME] & k.m2, 10);
    pattern_base = at_bits(chip_regs[REG_PATTERN] & k.m4, 11);
    color_base   = at_bits(chip_regs[REG_COLOR] & k.m3, 6);
    sattr_base   = at_bits(chip_regs[REG_SATTR] & k.m5, 7);
    spat_base    = at_bits(chip_regs[REG_SPAT], 11);
  endfunction

  function automatic void pick_mode(logic [7:0] r0, logic [7:0] r1);
    logic [4:0] key;
    logic [1:0] m;
    key = {r1[4:3], r0[3:1]};
    case (key)
      KEY_TEXT40: m = MODE_TEXT40;
      KEY_TEXT32: m = MODE_TEXT32;
      KEY_BITMAP: m = MODE_BITMAP;
      KEY_MULTI:  m = MODE_MULTI;
      default:    m = cur_mode;
    endcase
    if (m != cur_mode) begin
      rebase_tables(m);
      cur_mode = m;
    end
  endfunction

  function automatic void load_chip_reg(logic [2:0] idx, logic [7:0] v);
    masks_t k;
    logic [7:0] val;
    k = table_masks(cur_mode);
    val = v;
    case (idx)
      REG_MODE0:   pick_mode(v, chip_regs[REG_MODE1]);
      REG_MODE1:   pick_mode(chip_regs[REG_MODE0], v);
      REG_NAME:    name_base = at_bits(v & k.m2, 10);
      REG_COLOR:   color_base = at_bits(v & k.m3, 6);
      REG_PATTERN: pattern_base = at_bits(v & k.m4, 11);
      REG_SATTR:   sattr_base = at_bits(v & k.m5, 7);
      REG_SPAT: begin
        val = v & REG6_MASK;
        spat_base = at_bits(val, 11);
      end
      default: begin
        fg_nib = v[7:4];
        bg_nib = v[3:0];
      end
    endcase
    chip_regs[idx] = val;
  endfunction

  function automatic void power_up_model();
    foreach (vram_img[i]) vram_img[i] = VRAM_FILL;
    foreach (chip_regs[i]) chip_regs[i] = 8'h00;
    chip_regs[REG_MODE1] = REG1_RESET;
    wr_ptr = '0;
    rd_ptr = '0;
    latch_armed = 1'b1;
    latch_lo = 8'h00;
    status_byte = STATUS_RESET;
    cur_mode = MODE_TEXT40;
    name_base = '0;
    color_base = '0;
    pattern_base = '0;
    sattr_base = '0;
    spat_base = '0;
    fg_nib = '0;
    bg_nib = '0;
  endfunction

  // Apply one bus transaction to the shadow state and return the result it yields
  function automatic res_t port_step(logic [2:0] op, logic [7:0] d);
    res_t r;
    r = '0;
    case (op)
      OP_DATA_RD: begin
        r.read_data = vram_img[rd_ptr];
        rd_ptr = rd_ptr + 14'd1;
      end
      OP_STATUS_RD: begin
        r.read_data = status_byte;
        status_byte = status_byte & STATUS_RD_MASK;
        latch_armed = 1'b1;
      end
      OP_DATA_WR: begin
        if (latch_armed) begin
          vram_img[wr_ptr] = d;
          wr_ptr = wr_ptr + 14'd1;
        end
      end
      OP_CTRL_WR: begin
        if (latch_armed) begin
          latch_lo = d;
          latch_armed = 1'b0;
        end else begin
          latch_armed = 1'b1;
          case (d[7:6])
            CW_REG_WRITE:  load_chip_reg(d[2:0], latch_lo);
            CW_WRITE_ADDR: wr_ptr = {d[5:0], latch_lo};
            CW_READ_ADDR:  rd_ptr = {d[5:0], latch_lo};
            default: ;
          endcase
        end
      end
      OP_FRAME_END: begin
        status_byte = (status_byte & STATUS_FE_MASK) | STATUS_VBLANK;
        r.vblank_interrupt = latch_armed && chip_regs[REG_MODE1][IRQ_ENABLE_BIT];
      end
      default: ;
    endcase
    r.mode_out            = cur_mode;
    r.name_table_addr     = name_base;
    r.color_table_addr    = color_base;
    r.pattern_table_addr  = pattern_base;
    r.sprite_attr_addr    = sattr_base;
    r.sprite_pattern_addr = spat_base;
    r.fore_color          = fg_nib;
    r.back_color          = bg_nib;
    return r;
  endfunction

  // Stimulus helpers
  task automatic push_access(logic [2:0] op, logic [7:0] d, bit drain = 1'b0);
    bus_access_t a;
    a.op = op;
    a.data = d;
    a.drain = drain;
    bus_ops.push_back(a);
  endtask

  task automatic load_reg(logic [2:0] idx, logic [7:0] v);
    push_access(OP_CTRL_WR, v);
    push_access(OP_CTRL_WR, {CW_REG_WRITE, 3'($urandom), idx});
  endtask

  task automatic aim_writes(logic [13:0] a);
    push_access(OP_CTRL_WR, a[7:0]);
    push_access(OP_CTRL_WR, {CW_WRITE_ADDR, a[13:8]});
  endtask

  task automatic aim_reads(logic [13:0] a);
    push_access(OP_CTRL_WR, a[7:0]);
    push_access(OP_CTRL_WR, {CW_READ_ADDR, a[13:8]});
  endtask

  // Mostly a small window so reads find earlier writes; sometimes the top of memory or anywhere
  function automatic logic [13:0] pick_addr();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 14'($urandom_range(0, 127));
    if (sel < 8) return 14'($urandom_range(VRAM_DEPTH_DEF - 8, VRAM_DEPTH_DEF - 1));
    return 14'($urandom_range(0, VRAM_DEPTH_DEF - 1));
  endfunction

  function automatic int idle_pct(int done, bit sender);
    if (done * 3 < total_ops) return sender ? 22 : 59;
    if (done * 3 < total_ops * 2) return sender ? 59 : 22;
    return 0;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  // Directed cases, random sequences, then the end of the run
  initial begin
    logic [7:0] v;
    int n;
    int directed;
    bit mid_drain;

    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_DATA_RD;
    cmd_ch.data_in = 8'h00;
    res_ch.ready = 1'b0;
    mid_drain = 1'b0;
    power_up_model();

    // power-up values, interrupt disabled, colors, mode change, masked base
    push_access(OP_STATUS_RD, 8'h00);
    push_access(OP_DATA_RD, 8'h00);
    push_access(OP_FRAME_END, 8'h00);
    load_reg(REG_COLORS, 8'hA5);
    load_reg(REG_MODE1, 8'h20);
    load_reg(REG_PATTERN, 8'hFF);
    push_access(OP_FRAME_END, 8'hFF);
    // half-written control pair: no interrupt, data write ignored, no-op action
    push_access(OP_CTRL_WR, 8'h34);
    push_access(OP_FRAME_END, 8'h00);
    push_access(OP_DATA_WR, 8'hC3);
    push_access(OP_CTRL_WR, 8'hC0);
    // address wrap at the top of memory
    aim_writes(14'h3FFF);
    push_access(OP_DATA_WR, 8'h00);
    push_access(OP_DATA_WR, 8'hFF);
    aim_reads(14'h3FFF);
    push_access(OP_DATA_RD, 8'h00);
    push_access(OP_DATA_RD, 8'h00);
    // unused opcodes
    push_access(3'd5, 8'hFF);
    push_access(3'd7, 8'h00, 1'b1);
    directed = bus_ops.size();

    while (bus_ops.size() < directed + RANDOM_ITEMS) begin
      if (!mid_drain && bus_ops.size() >= directed + RANDOM_ITEMS / 2) begin
        push_access(OP_STATUS_RD, 8'h00, 1'b1);
        mid_drain = 1'b1;
      end
      case ($urandom_range(0, 9)) inside
        0: push_access(OP_STATUS_RD, 8'($urandom));
        1, 2: begin
          if ($urandom_range(0, 9) < 4) push_access(OP_STATUS_RD, 8'h00);
          aim_writes(pick_addr());
          n = $urandom_range(1, 6);
          repeat (n) push_access(OP_DATA_WR, 8'($urandom));
        end
        3, 4: begin
          if ($urandom_range(0, 9) < 4) push_access(OP_STATUS_RD, 8'h00);
          aim_reads(pick_addr());
          n = $urandom_range(1, 6);
          repeat (n) push_access(OP_DATA_RD, 8'($urandom));
        end
        5, 6: begin
          if ($urandom_range(0, 9) < 4) push_access(OP_STATUS_RD, 8'h00);
          n = $urandom_range(0, 7);
          v = 8'($urandom);
          // steer mode registers toward recognized keys half the time
          if (n == REG_MODE0 && $urandom_range(0, 1)) v[3:1] = 3'($urandom_range(0, 1));
          if (n == REG_MODE1 && $urandom_range(0, 1)) v[4:3] = 2'($urandom_range(0, 2));
          load_reg(3'(n), v);
        end
        7: push_access(OP_FRAME_END, 8'($urandom));
        8: push_access(3'($urandom_range(0, 7)), 8'($urandom));
        default: begin
          // lone control byte followed by a random access
          push_access(OP_CTRL_WR, 8'($urandom));
          push_access(3'($urandom_range(0, 4)), 8'($urandom));
          if ($urandom_range(0, 1)) push_access(OP_STATUS_RD, 8'h00);
        end
      endcase
    end
    total_ops = bus_ops.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (bus_ops.size() != 0 || cmd_ch.valid || predicted.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && predicted.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Command driver: predicts each accepted transaction, then offers the next
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted.push_back(port_step(cmd_ch.opcode, cmd_ch.data_in));
        cmds_taken++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (bus_ops.size() != 0 && !(bus_ops[0].drain && predicted.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(cmds_taken, 1'b1)) begin
          cmd_ch.valid   <= 1'b1;
          cmd_ch.opcode  <= bus_ops[0].op;
          cmd_ch.data_in <= bus_ops[0].data;
          void'(bus_ops.pop_front());
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure so the pipeline fills and stalls the command side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_started == 0 && results_seen >= 150) ||
                 (holds_started == 1 && results_seen >= 400)) begin
      hold_left <= HOLD_CYCLES;
      holds_started++;
    end
  end

  // Result monitor: checks each transaction against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (predicted.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual read_data 0x%0h",
                   $time, res_ch.read_data);
          errors++;
        end else begin
          want = predicted.pop_front();
          check_field("read_data", want.read_data, res_ch.read_data);
          check_field("vblank_interrupt", want.vblank_interrupt, res_ch.vblank_interrupt);
          check_field("mode_out", want.mode_out, res_ch.mode_out);
          check_field("name_table_addr", want.name_table_addr, res_ch.name_table_addr);
          check_field("color_table_addr", want.color_table_addr, res_ch.color_table_addr);
          check_field("pattern_table_addr", want.pattern_table_addr,
                      res_ch.pattern_table_addr);
          check_field("sprite_attr_addr", want.sprite_attr_addr, res_ch.sprite_attr_addr);
          check_field("sprite_pattern_addr", want.sprite_pattern_addr,
                      res_ch.sprite_pattern_addr);
          check_field("fore_color", want.fore_color, res_ch.fore_color);
          check_field("back_color", want.back_color, res_ch.back_color);
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= idle_pct(results_seen, 1'b0));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
